// ===== hw/rtl/cbb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and command codes for the circular byte buffer.
// Used by cbb_ctrl, cbb_datapath and circular_byte_buffer_unit; no dependencies.
package cbb_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 8;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int BANKS  = 8;
    localparam int BANK_W = $clog2(BANKS);
    localparam int ROWS   = DEPTH / BANKS;
    localparam int ROW_W  = $clog2(ROWS);

    localparam int CMD_W   = 2;
    localparam int CNT_W   = 4;
    localparam int DATA_W  = 64;
    localparam int MOVE_W  = 12;
    localparam int FILL_W  = 10;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_MOVE  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/circular_byte_buffer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the circular byte buffer: joins controller and datapath.
// Depends on cbb_pkg, cbb_ctrl and cbb_datapath.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata: command, byte_count, write_bytes, move_amount
//  m_       out        m_tvalid/m_tready  m_tdata: status, read_bytes, fill_level
//
// Each transaction executes against the banked store in the execute state (eight
// byte banks, one port each, registered read) and then loads the result register;
// the next transaction is accepted on the edge that loads the result.
// Reset (aresetn low, synchronous) clears pointers and fill count; the store is not cleared.
// With m_tready low, one result is held and input acceptance stops after the next item.
module circular_byte_buffer_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbb_pkg::S_TDATA_W-1:0] s_tdata,  // command, byte_count, write_bytes, move_amount
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbb_pkg::M_TDATA_W-1:0] m_tdata   // status, read_bytes, fill_level
);

    cbb_pkg::ctrl_cmd_t cmd;

    cbb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cbb_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ===== hw/rtl/cbb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the circular byte buffer: sequences accept, execute and result load.
// Depends on cbb_pkg.
module cbb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output cbb_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;
    logic   load_out;
    logic   accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == S_FIN) && out_free;
    assign s_tready = (state_reg == S_IDLE) || load_out;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    assign cmd.load_item = accept;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.load_out  = load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= accept ? S_EXEC : S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not move to execute");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/cbb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the circular byte buffer: item register, pointers, fill count,
// banked byte store and result register. Depends on cbb_pkg.
module cbb_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cbb_pkg::ctrl_cmd_t              cmd,
    input  logic [cbb_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic [cbb_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam logic signed [cbb_pkg::MOVE_W-1:0] MOVE_LIM = cbb_pkg::MOVE_W'(cbb_pkg::DEPTH);

    cbb_pkg::cmd_t                       op_reg;
    logic [cbb_pkg::CNT_W-1:0]           len_reg;
    logic [cbb_pkg::DATA_W-1:0]          wdata_reg;
    logic signed [cbb_pkg::MOVE_W-1:0]   mv_reg;

    logic [cbb_pkg::PTR_W-1:0]           rp_reg, rp_next;
    logic [cbb_pkg::PTR_W-1:0]           wp_reg, wp_next;
    logic [cbb_pkg::PTR_W-1:0]           fill_reg, fill_next;

    logic                                reject_reg, reject;
    logic                                rd_ok_reg;
    logic [cbb_pkg::BANK_W-1:0]          rd_lo_reg;

    logic                                m_status_reg;
    logic [cbb_pkg::DATA_W-1:0]          m_rdata_reg, rdata_next;
    logic [cbb_pkg::FILL_W-1:0]          m_fill_reg;

    logic [7:0]                          mem [cbb_pkg::BANKS][cbb_pkg::ROWS];
    logic [7:0]                          bank_q_reg [cbb_pkg::BANKS];
    logic [cbb_pkg::ROW_W-1:0]           bank_row [cbb_pkg::BANKS];
    logic [cbb_pkg::BANK_W-1:0]          bank_off [cbb_pkg::BANKS];
    logic                                bank_we [cbb_pkg::BANKS];
    logic                                bank_re;
    logic [cbb_pkg::PTR_W-1:0]           base_ptr;
    logic                                len_ok;
    logic                                wr_go;

    assign len_ok = (len_reg <= cbb_pkg::CNT_W'(cbb_pkg::MAX_BURST));

    always_comb begin
        reject    = 1'b0;
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        case (op_reg)
            cbb_pkg::CMD_WRITE: begin
                reject = !len_ok || (({1'b0, fill_reg} + (cbb_pkg::PTR_W + 1)'(len_reg))
                         >= (cbb_pkg::PTR_W + 1)'(cbb_pkg::DEPTH));
                if (!reject) begin
                    wp_next   = wp_reg + cbb_pkg::PTR_W'(len_reg);
                    fill_next = fill_reg + cbb_pkg::PTR_W'(len_reg);
                end
            end
            cbb_pkg::CMD_READ: begin
                reject = !len_ok || (fill_reg < cbb_pkg::PTR_W'(len_reg));
                if (!reject) begin
                    rp_next   = rp_reg + cbb_pkg::PTR_W'(len_reg);
                    fill_next = fill_reg - cbb_pkg::PTR_W'(len_reg);
                end
            end
            cbb_pkg::CMD_MOVE: begin
                reject = (mv_reg > MOVE_LIM) || (mv_reg < -MOVE_LIM);
                if (!reject) begin
                    rp_next   = rp_reg + mv_reg[cbb_pkg::PTR_W-1:0];
                    fill_next = fill_reg - mv_reg[cbb_pkg::PTR_W-1:0];
                end
            end
            cbb_pkg::CMD_CLEAR: begin
                rp_next   = '0;
                wp_next   = '0;
                fill_next = '0;
            end
            default: begin
                reject = 1'b1;
            end
        endcase
    end

    assign wr_go    = cmd.exec && (op_reg == cbb_pkg::CMD_WRITE) && !reject;
    assign bank_re  = cmd.exec && (op_reg == cbb_pkg::CMD_READ);
    assign base_ptr = (op_reg == cbb_pkg::CMD_WRITE) ? wp_reg : rp_reg;

    always_comb begin
        logic [cbb_pkg::PTR_W-1:0] addr;
        for (int b = 0; b < cbb_pkg::BANKS; b++) begin
            bank_off[b] = cbb_pkg::BANK_W'(b) - base_ptr[cbb_pkg::BANK_W-1:0];
            addr        = base_ptr + cbb_pkg::PTR_W'(bank_off[b]);
            bank_row[b] = addr[cbb_pkg::PTR_W-1:cbb_pkg::BANK_W];
            bank_we[b]  = wr_go && (cbb_pkg::CNT_W'(bank_off[b]) < len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        for (int b = 0; b < cbb_pkg::BANKS; b++) begin
            if (bank_we[b]) begin
                mem[b][bank_row[b]] <= wdata_reg[8*bank_off[b] +: 8];
            end
            if (bank_re) begin
                bank_q_reg[b] <= mem[b][bank_row[b]];
            end
        end
    end

    always_comb begin
        logic [cbb_pkg::BANK_W-1:0] idx;
        rdata_next = '0;
        for (int i = 0; i < cbb_pkg::MAX_BURST; i++) begin
            idx = rd_lo_reg + cbb_pkg::BANK_W'(i);
            if (rd_ok_reg && (cbb_pkg::CNT_W'(i) < len_reg)) begin
                rdata_next[8*i +: 8] = bank_q_reg[idx];
            end
        end
    end

    // Item, execute and result registers: no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= cbb_pkg::cmd_t'(s_tdata[1:0]);
            len_reg   <= s_tdata[5:2];
            wdata_reg <= s_tdata[69:6];
            mv_reg    <= s_tdata[81:70];
        end
        if (cmd.exec) begin
            reject_reg <= reject;
            rd_ok_reg  <= (op_reg == cbb_pkg::CMD_READ) && !reject;
            rd_lo_reg  <= rp_reg[cbb_pkg::BANK_W-1:0];
        end
        if (cmd.load_out) begin
            m_status_reg <= reject_reg;
            m_rdata_reg  <= rdata_next;
            m_fill_reg   <= cbb_pkg::FILL_W'(fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (cmd.exec) begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    assign m_tdata = {5'd0, m_fill_reg, m_rdata_reg, m_status_reg};

    a_ptr_fill_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cbb_pkg::PTR_W'(wp_reg - rp_reg) == fill_reg))
        else $error("pointer distance and fill count disagree");

    a_write_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_go |=> (fill_reg == $past(fill_reg + cbb_pkg::PTR_W'(len_reg))))
        else $error("fill count not advanced by write length");

endmodule

// ===== tb/circular_byte_buffer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_byte_buffer_unit: drives command transactions and
// checks each result against an in-bench model of the byte ring. Depends on cbb_pkg and circular_byte_buffer_unit.
module circular_byte_buffer_unit_tb;

    typedef struct packed {
        logic                       status;
        logic [cbb_pkg::DATA_W-1:0] rdata;
        logic [cbb_pkg::FILL_W-1:0] fill;
    } buf_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [cbb_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cbb_pkg::M_TDATA_W-1:0] m_tdata;

    // ring model state
    logic [7:0]  ring_data [cbb_pkg::DEPTH];
    bit          ring_valid [cbb_pkg::DEPTH];
    int          ring_written_total = 0;
    int          ring_rd   = 0;
    int          ring_wr   = 0;
    int          ring_fill = 0;

    buf_result_t pending_results [$];
    int          tx_idle_pct    = 7;
    int          rx_idle_pct    = 51;
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          reject_count   = 0;
    int          cmd_count [4]  = '{0, 0, 0, 0};

    circular_byte_buffer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // command, byte_count, write_bytes, move_amount
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, read_bytes, fill_level
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic buf_result_t predict_ring(input cbb_pkg::cmd_t cmd,
                                                 input logic [3:0] len,
                                                 input logic [cbb_pkg::DATA_W-1:0] wdata,
                                                 input logic signed [cbb_pkg::MOVE_W-1:0] mv);
        buf_result_t res;
        int n;
        int shift;
        int i;
        res   = '0;
        n     = int'(len);
        shift = int'(mv);
        case (cmd)
            cbb_pkg::CMD_WRITE: begin
                if (n > cbb_pkg::MAX_BURST || ring_fill + n >= cbb_pkg::DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    for (i = 0; i < n; i++) begin
                        ring_data[ring_wr] = wdata[8*i +: 8];
                        if (!ring_valid[ring_wr]) ring_written_total++;
                        ring_valid[ring_wr] = 1'b1;
                        ring_wr = (ring_wr + 1) % cbb_pkg::DEPTH;
                    end
                    ring_fill = (ring_fill + n) % cbb_pkg::DEPTH;
                end
            end
            cbb_pkg::CMD_READ: begin
                if (n > cbb_pkg::MAX_BURST || ring_fill < n) begin
                    res.status = 1'b1;
                end else begin
                    for (i = 0; i < n; i++) begin
                        res.rdata[8*i +: 8] = ring_data[ring_rd];
                        ring_rd = (ring_rd + 1) % cbb_pkg::DEPTH;
                    end
                    ring_fill = ring_fill - n;
                end
            end
            cbb_pkg::CMD_MOVE: begin
                if (shift > cbb_pkg::DEPTH || shift < -cbb_pkg::DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    ring_rd   = (ring_rd + shift + cbb_pkg::DEPTH) % cbb_pkg::DEPTH;
                    ring_fill = (ring_fill - shift + cbb_pkg::DEPTH) % cbb_pkg::DEPTH;
                end
            end
            default: begin
                ring_rd   = 0;
                ring_wr   = 0;
                ring_fill = 0;
            end
        endcase
        res.fill = ring_fill[cbb_pkg::FILL_W-1:0];
        return res;
    endfunction

    // an accepted read must only cover bytes written since reset
    function automatic bit read_hits_unwritten(input logic [3:0] len);
        int i;
        if (int'(len) > cbb_pkg::MAX_BURST || ring_fill < int'(len)) return 1'b0;
        for (i = 0; i < int'(len); i++) begin
            if (!ring_valid[(ring_rd + i) % cbb_pkg::DEPTH]) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_command(input cbb_pkg::cmd_t cmd, input logic [3:0] len,
                                input logic [cbb_pkg::DATA_W-1:0] wdata,
                                input logic signed [cbb_pkg::MOVE_W-1:0] mv);
        buf_result_t exp_res;
        logic [3:0]  eff_len;
        eff_len = len;
        if (cmd == cbb_pkg::CMD_READ && read_hits_unwritten(eff_len)) eff_len = '0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        exp_res = predict_ring(cmd, eff_len, wdata, mv);
        pending_results.push_back(exp_res);
        cmd_count[int'(cmd)]++;
        if (exp_res.status) reject_count++;
        s_tvalid <= 1'b1;
        s_tdata  <= cbb_pkg::S_TDATA_W'({mv, wdata, eff_len, cmd});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input buf_result_t exp_res,
                                   input buf_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected status=%0d data=%h fill=%0d,",
                     $realtime, what, exp_res.status, exp_res.rdata, exp_res.fill);
            $display("    got status=%0d data=%h fill=%0d",
                     got.status, got.rdata, got.fill);
        end
    endtask

    always @(posedge aclk) begin
        buf_result_t got;
        buf_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[0];
            got.rdata  = m_tdata[cbb_pkg::DATA_W:1];
            got.fill   = m_tdata[cbb_pkg::DATA_W+cbb_pkg::FILL_W:cbb_pkg::DATA_W+1];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                exp_res = pending_results.pop_front();
                if (got.status !== exp_res.status || got.rdata !== exp_res.rdata ||
                    got.fill !== exp_res.fill) begin
                    report_mismatch("result mismatch", exp_res, got);
                end
            end
        end
    end

    task automatic test_burst_limits();
        send_command(cbb_pkg::CMD_READ,  4'd1,  64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_READ,  4'd0,  64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_WRITE, 4'd0,  64'hDEAD_BEEF_0000_1111, 12'sd0);
        send_command(cbb_pkg::CMD_WRITE, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 12'sd0);
        send_command(cbb_pkg::CMD_WRITE, 4'd8,  64'h0123_4567_89AB_CDEF, 12'sd0);
        send_command(cbb_pkg::CMD_WRITE, 4'd9,  64'hAAAA_5555_AAAA_5555, 12'sd0);
        send_command(cbb_pkg::CMD_READ,  4'd15, 64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_READ,  4'd8,  64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_READ,  4'd3,  64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_READ,  4'd5,  64'h0, 12'sd0);
    endtask

    task automatic test_move_range();
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, 12'sd1024);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, -12'sd1024);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, 12'sd1025);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, -12'sd1025);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, 12'sd2047);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, -12'sd2048);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, -12'sd4);
        send_command(cbb_pkg::CMD_READ, 4'd4, 64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, 12'sd3);
        send_command(cbb_pkg::CMD_MOVE, 4'd0, 64'h0, -12'sd3);
    endtask

    task automatic test_full_ring();
        send_command(cbb_pkg::CMD_MOVE,  4'd0, 64'h0, -12'sd1015);
        send_command(cbb_pkg::CMD_WRITE, 4'd8, 64'h8877_6655_4433_2211, 12'sd0);
        send_command(cbb_pkg::CMD_WRITE, 4'd1, 64'h0000_0000_0000_00C3, 12'sd0);
        send_command(cbb_pkg::CMD_CLEAR, 4'd0, 64'h0, 12'sd0);
        send_command(cbb_pkg::CMD_READ,  4'd1, 64'h0, 12'sd0);
    endtask

    // paired bursts until every store entry has been written and both pointers wrapped
    task automatic test_store_wrap();
        logic [3:0] len;
        while (ring_written_total < cbb_pkg::DEPTH || ring_wr < 64) begin
            len = 4'($urandom_range(4, cbb_pkg::MAX_BURST));
            send_command(cbb_pkg::CMD_WRITE, len, {$urandom, $urandom}, 12'($urandom));
            if ($urandom_range(0, 7) == 0)
                send_command(cbb_pkg::CMD_READ, 4'($urandom_range(9, 15)),
                             {$urandom, $urandom}, 12'sd0);
            send_command(cbb_pkg::CMD_READ, len, {$urandom, $urandom}, 12'($urandom));
        end
    endtask

    task automatic test_random_mix(input int n_items);
        int         pick;
        logic [3:0] len;
        logic signed [cbb_pkg::MOVE_W-1:0] mv;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, cbb_pkg::MAX_BURST));
            mv   = ($urandom_range(0, 2) == 0) ? cbb_pkg::MOVE_W'($urandom)
                   : cbb_pkg::MOVE_W'(int'($urandom_range(0, 32)) - 16);
            if (pick < 40)
                send_command(cbb_pkg::CMD_WRITE, len, {$urandom, $urandom}, mv);
            else if (pick < 82)
                send_command(cbb_pkg::CMD_READ, len, {$urandom, $urandom}, mv);
            else if (pick < 97)
                send_command(cbb_pkg::CMD_MOVE, len, {$urandom, $urandom}, mv);
            else
                send_command(cbb_pkg::CMD_CLEAR, len, {$urandom, $urandom}, mv);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_burst_limits();
        test_move_range();
        test_full_ring();
        test_store_wrap();
        hold_until_drained();

        tx_idle_pct = 51;
        rx_idle_pct = 7;
        test_random_mix(130);
        hold_until_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_mix(130);
        hold_until_drained();
        repeat (10) @(posedge aclk);

        $display("Ran %0d transactions (%0d write, %0d read, %0d move, %0d clear),",
                 results_seen, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3]);
        $display("%0d rejected, with the store fully wrapped and %0d mismatches.",
                 reject_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
